FILE: hdl/ssvu_pkg.sv
package ssvu_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned ORIGIN_W = 9;
  localparam int unsigned PITCH_W = 8;
  localparam int unsigned X_W = 11;
  localparam int unsigned SEG_W = 7;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X = 2'd1;
  localparam logic [1:0] REG_DIGIT_PITCH = 2'd2;

  // Register reset values
  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 3'd5;
  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 9'd0;
  localparam logic [PITCH_W-1:0] DIGIT_PITCH_RST = 8'd70;

  // Stored code after reset: all segments lit, digit eight
  localparam logic [SEG_W-1:0] SEG_EIGHT = 7'h7F;

  // Divide by ten: q = (v * RECIP_10) >> RECIP_SHIFT, exact for 16-bit v
  localparam logic [15:0] RECIP_10 = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic [COUNT_W-1:0]  digit_count;
    logic [ORIGIN_W-1:0] origin_x;
    logic [PITCH_W-1:0]  digit_pitch;
  } ssvu_cfg_t;

  // One update job handed from the front to the back
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } ssvu_job_t;

  // Segment code of a decimal digit
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    case (digit)
      4'd0: code = 7'h3F;
      4'd1: code = 7'h03;
      4'd2: code = 7'h76;
      4'd3: code = 7'h67;
      4'd4: code = 7'h4B;
      4'd5: code = 7'h6D;
      4'd6: code = 7'h7D;
      4'd7: code = 7'h07;
      4'd8: code = 7'h7F;
      4'd9: code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/ssvu_front.sv
module ssvu_front #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  // APB register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssvu_pkg::ADDR_W-1:0]    paddr,
  input  logic [ssvu_pkg::DATA_W-1:0]    pwdata,
  output logic [ssvu_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ssvu_pkg::VALUE_W-1:0]   s_tdata,   // [15:0] value
  // to the queue
  output logic                           push,
  output ssvu_pkg::ssvu_job_t            push_job,
  input  logic                           q_full,
  output ssvu_pkg::ssvu_cfg_t            cfg
);

  localparam logic [ssvu_pkg::COUNT_W-1:0] MAX_CNT = ssvu_pkg::COUNT_W'(MAX_DIGITS);

  logic                            wr_en;
  logic [ssvu_pkg::COUNT_W-1:0]    eff_count;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.digit_count <= ssvu_pkg::DIGIT_COUNT_RST;
      cfg.origin_x <= ssvu_pkg::ORIGIN_X_RST;
      cfg.digit_pitch <= ssvu_pkg::DIGIT_PITCH_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        ssvu_pkg::REG_DIGIT_COUNT: cfg.digit_count <= pwdata[ssvu_pkg::COUNT_W-1:0];
        ssvu_pkg::REG_ORIGIN_X: cfg.origin_x <= pwdata[ssvu_pkg::ORIGIN_W-1:0];
        ssvu_pkg::REG_DIGIT_PITCH: cfg.digit_pitch <= pwdata[ssvu_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      ssvu_pkg::REG_DIGIT_COUNT:
        prdata = ssvu_pkg::DATA_W'(cfg.digit_count);
      ssvu_pkg::REG_ORIGIN_X:
        prdata = ssvu_pkg::DATA_W'(cfg.origin_x);
      ssvu_pkg::REG_DIGIT_PITCH:
        prdata = ssvu_pkg::DATA_W'(cfg.digit_pitch);
      default:
        prdata = '0;
    endcase
  end

  // Clamp the digit count; drop items that update no digit
  assign eff_count = (cfg.digit_count > MAX_CNT) ? MAX_CNT : cfg.digit_count;
  assign s_tready = !q_full;
  assign push = s_tvalid && s_tready && (eff_count != '0);
  assign push_job.value = s_tdata;
  assign push_job.count = eff_count;

endmodule

FILE: hdl/ssvu_queue.sv
module ssvu_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ssvu_pkg::ssvu_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output ssvu_pkg::ssvu_job_t pop_job
);

  ssvu_pkg::ssvu_job_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign pop_job = entry[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/ssvu_back.sv
module ssvu_back #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ssvu_pkg::ssvu_cfg_t                 cfg,
  // from the queue
  input  logic                                q_valid,
  input  ssvu_pkg::ssvu_job_t                 q_job,
  output logic                                pop,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ssvu_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast
);

  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                          busy;
  logic [ssvu_pkg::VALUE_W-1:0]  rest;
  logic [ssvu_pkg::COUNT_W-1:0]  idx;
  logic [ssvu_pkg::COUNT_W-1:0]  cnt;
  logic [ssvu_pkg::X_W-1:0]      x;
  logic [ssvu_pkg::SEG_W-1:0]    prev [MAX_DIGITS];

  logic                          out_free;
  logic                          step;
  logic                          final_digit;
  logic [31:0]                   prod;
  logic [ssvu_pkg::VALUE_W-1:0]  quot;
  logic [ssvu_pkg::VALUE_W-1:0]  rem;
  logic [ssvu_pkg::SEG_W-1:0]    now_code;
  logic [ssvu_pkg::SEG_W-1:0]    before_code;

  assign out_free = !m_tvalid || m_tready;
  assign step = busy && out_free;
  assign pop = !busy && q_valid;
  assign final_digit = ((idx + 3'd1) == cnt);

  // One division by ten per digit
  assign prod = 32'(rest) * 32'(ssvu_pkg::RECIP_10);
  assign quot = ssvu_pkg::VALUE_W'(prod[31:ssvu_pkg::RECIP_SHIFT]);
  assign rem = rest - ((quot << 3) + (quot << 1));
  assign now_code = ssvu_pkg::seg_code(rem[3:0]);
  assign before_code = prev[idx[IDX_W-1:0]];

  // Digit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (step && final_digit) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rest <= q_job.value;
      cnt <= q_job.count;
      idx <= '0;
      x <= ssvu_pkg::X_W'(cfg.origin_x);
    end else if (step) begin
      rest <= quot;
      idx <= idx + 3'd1;
      x <= x + ssvu_pkg::X_W'(cfg.digit_pitch);
    end
  end

  // Previous codes per position
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(MAX_DIGITS); i++) begin
        prev[i] <= ssvu_pkg::SEG_EIGHT;
      end
    end else if (step) begin
      prev[idx[IDX_W-1:0]] <= now_code;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {4'd0, now_code, before_code & ~now_code, x, idx};
      m_tlast <= final_digit;
    end
  end

  // Checks
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0) && (idx < cnt))
    else $error("digit index out of range while busy");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (step && final_digit) |=> !busy && m_tvalid && m_tlast)
    else $error("sequencer did not finish on final digit");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pop)
    else $error("queue popped while a job is running");

endmodule

FILE: hdl/seven_segment_value_updater_core.sv
// An accepted item's first digit passes through the queue, a load into the back
// sequencer and the output register; then one digit per cycle while the output is taken.
// Each item takes a load step plus one divide-by-ten step per digit in the back
// sequencer; a 2-entry queue buffers items ahead while a job runs, until it is full.
// Reset: digit_count 5, origin_x 0, digit_pitch 70, all stored codes 0x7F
// (digit eight), queue and output empty.
module seven_segment_value_updater_core #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ssvu_pkg::ADDR_W-1:0]         paddr,
  input  logic [ssvu_pkg::DATA_W-1:0]         pwdata,
  output logic [ssvu_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ssvu_pkg::VALUE_W-1:0]        s_tdata,  // [15:0] value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] digit_index, [13:3] x_pos, [20:14] erase_mask, [27:21] draw_mask
  output logic [ssvu_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast
);

  ssvu_pkg::ssvu_cfg_t cfg;
  ssvu_pkg::ssvu_job_t push_job;
  ssvu_pkg::ssvu_job_t pop_job;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_valid;

  ssvu_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full),
    .cfg      (cfg)
  );

  ssvu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  ssvu_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_job    (pop_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
